/* hw/rtl/frb_pkg.sv */
// ----------------------------------------------------------------------------
// frb_pkg
// Shared types, widths and codes for the frame ring buffer with drop policy.
// ----------------------------------------------------------------------------
`default_nettype none

package frb_pkg;

    // Fixed field widths.
    localparam int LEN_W  = 10;
    localparam int BYTE_W = 8;
    localparam int STAT_W = 2;
    localparam int DROP_W = 9;
    // A stored span is at most four header bytes, 1023 data bytes and seven fill bytes.
    localparam int SPAN_W = LEN_W + 1;

    // Stream bus widths.
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 2;

    // Configuration port.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_DROP_OLDEST = 1'b0;

    // Parameter defaults.
    localparam int DEF_BUF_BYTES   = 1024;
    localparam int DEF_HEAD_BYTES  = 2;
    localparam int DEF_ALIGN_BYTES = 2;

    // Operation codes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_REJECT  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STAT_W-1:0] ST_DISCARD = 2'd3;

    // One input item.
    typedef struct packed {
        logic              operation;
        logic              first_of_frame;
        logic [LEN_W-1:0]  frame_length;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  read_limit;
    } t_item;

    // One result item.
    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        logic [STAT_W-1:0] status;
        logic              end_of_frame;
        logic [DROP_W-1:0] frames_dropped;
    } t_result;

endpackage

`default_nettype wire

/* hw/rtl/frb_ram.sv */
// ----------------------------------------------------------------------------
// frb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module frb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hw/rtl/frb_span.sv */
// ----------------------------------------------------------------------------
// frb_span
// Shared span unit: header plus data rounded up to the alignment; the result is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module frb_span
    import frb_pkg::*;
#(
    parameter int HEAD_BYTES  = DEF_HEAD_BYTES,
    parameter int ALIGN_BYTES = DEF_ALIGN_BYTES,
    localparam int FILL_W = (ALIGN_BYTES > 1) ? $clog2(ALIGN_BYTES) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [LEN_W-1:0]  i_len,
    output logic                   o_done,
    output logic      [SPAN_W-1:0] o_span,
    output logic      [FILL_W-1:0] o_fill
);

    // The quotient by the alignment comes from a reciprocal; it is exact or one low.
    localparam int SH     = 16;
    localparam int RCP_W  = SH + 1;
    localparam int PROD_W = SPAN_W + RCP_W;
    localparam int RW     = SPAN_W + 4;
    localparam logic [RCP_W-1:0] RECIP = RCP_W'((1 << SH) / ALIGN_BYTES);

    logic [SPAN_W-1:0] x_c;
    logic [PROD_W-1:0] prod_c;
    logic [SPAN_W-1:0] q_c;
    logic [RW-1:0]     qa_c;
    logic [RW-1:0]     rc_c;
    logic [RW-1:0]     rem_c;
    logic [RW-1:0]     fill_c;

    logic              r_v1;
    logic [SPAN_W-1:0] r_x;
    logic [SPAN_W-1:0] r_q;
    logic              r_done;
    logic [SPAN_W-1:0] r_span;
    logic [FILL_W-1:0] r_fill;

    // Stage one: raw span and estimated quotient.
    always_comb begin
        x_c    = SPAN_W'(HEAD_BYTES) + SPAN_W'(i_len);
        prod_c = PROD_W'(x_c) * PROD_W'(RECIP);
        q_c    = SPAN_W'(prod_c >> SH);
    end

    // Stage two: remainder with a single correction, then the fill.
    always_comb begin
        qa_c   = RW'(r_q) * RW'(ALIGN_BYTES);
        rc_c   = RW'(r_x) - qa_c;
        rem_c  = (rc_c >= RW'(ALIGN_BYTES)) ? rc_c - RW'(ALIGN_BYTES) : rc_c;
        fill_c = (rem_c == '0) ? '0 : RW'(ALIGN_BYTES) - rem_c;
    end

    // Valid flags of the two stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_done <= r_v1;
        end
    end

    // Stage data.
    always_ff @(posedge i_clk) begin
        r_x    <= x_c;
        r_q    <= q_c;
        r_span <= r_x + SPAN_W'(fill_c);
        r_fill <= FILL_W'(fill_c);
    end

    assign o_done = r_done;
    assign o_span = r_span;
    assign o_fill = r_fill;

endmodule

`default_nettype wire

/* hw/rtl/frb_seq.sv */
// ----------------------------------------------------------------------------
// frb_seq
// Sequencer that drives the ring RAM and the shared span unit for each item.
// ----------------------------------------------------------------------------
`default_nettype none

module frb_seq
    import frb_pkg::*;
#(
    parameter int BUF_BYTES   = DEF_BUF_BYTES,
    parameter int HEAD_BYTES  = DEF_HEAD_BYTES,
    parameter int ALIGN_BYTES = DEF_ALIGN_BYTES
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_item_valid,
    output logic         o_item_ready,
    input  wire t_item   i_item,
    input  wire logic    i_drop_oldest,
    input  wire logic    i_out_free,
    output logic         o_res_valid,
    output t_result      o_res
);

    localparam int AW     = $clog2(BUF_BYTES);
    localparam int FREE_W = AW + 1;
    localparam int FILL_W = (ALIGN_BYTES > 1) ? $clog2(ALIGN_BYTES) : 1;
    localparam int HK_W   = (HEAD_BYTES > 1) ? $clog2(HEAD_BYTES) : 1;

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PUT   = 4'd1;
    localparam logic [3:0] S_PAD   = 4'd2;
    localparam logic [3:0] S_NSPAN = 4'd3;
    localparam logic [3:0] S_CHECK = 4'd4;
    localparam logic [3:0] S_HRD0  = 4'd5;
    localparam logic [3:0] S_HRD1  = 4'd6;
    localparam logic [3:0] S_HRD2  = 4'd7;
    localparam logic [3:0] S_RSPAN = 4'd8;
    localparam logic [3:0] S_HWR   = 4'd9;
    localparam logic [3:0] S_RDATA = 4'd10;
    localparam logic [3:0] S_RBYTE = 4'd11;
    localparam logic [3:0] S_ESPAN = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;

    // Control state.
    logic [3:0]        r_state,    n_state;
    logic [AW-1:0]     r_wp,       n_wp;
    logic [AW-1:0]     r_rp,       n_rp;
    logic [FREE_W-1:0] r_free,     n_free;
    logic [LEN_W-1:0]  r_wr_rem,   n_wr_rem;
    logic              r_wr_rej,   n_wr_rej;
    logic [LEN_W-1:0]  r_rd_rem,   n_rd_rem;
    logic [LEN_W-1:0]  r_rd_pos,   n_rd_pos;
    logic [AW-1:0]     r_complete, n_complete;
    logic [FILL_W-1:0] r_fill,     n_fill;
    logic              r_closing,  n_closing;

    // Working data.
    t_item             r_item,     n_item;
    t_result           r_res,      n_res;
    logic [LEN_W-1:0]  r_rd_len,   n_rd_len;
    logic [SPAN_W-1:0] r_new_span, n_new_span;
    logic [FILL_W-1:0] r_new_fill, n_new_fill;
    logic [BYTE_W-1:0] r_hb0,      n_hb0;
    logic [HK_W-1:0]   r_hk,       n_hk;

    // RAM and span unit hookup.
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;
    logic              span_start;
    logic [LEN_W-1:0]  span_len;
    logic              span_done;
    logic [SPAN_W-1:0] span_out;
    logic [FILL_W-1:0] fill_out;

    logic              frame_end;
    logic [LEN_W-1:0]  hlen;
    logic [31:0]       hdr_word;
    logic              len_bad;

    frb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUF_BYTES)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    frb_span #(
        .HEAD_BYTES  (HEAD_BYTES),
        .ALIGN_BYTES (ALIGN_BYTES)
    ) u_span (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (span_start),
        .i_len   (span_len),
        .o_done  (span_done),
        .o_span  (span_out),
        .o_fill  (fill_out)
    );

    // Header helpers: length rebuilt from the low header bytes, header byte to write, length screen.
    always_comb begin
        if (HEAD_BYTES >= 2) begin
            hlen = LEN_W'({ram_rdata, r_hb0});
        end else begin
            hlen = LEN_W'(r_hb0);
        end
        hdr_word = 32'(r_item.frame_length) >> {r_hk, 3'b000};
        len_bad  = (r_item.frame_length == '0) || (32'(span_out) > BUF_BYTES) ||
                   ((32'(r_item.frame_length) >> (8 * HEAD_BYTES)) != 32'd0);
    end

    assign o_item_ready = (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_DONE) && i_out_free;
    assign o_res        = r_res;

    // Next-state and datapath control.
    always_comb begin
        n_state    = r_state;
        n_wp       = r_wp;
        n_rp       = r_rp;
        n_free     = r_free;
        n_wr_rem   = r_wr_rem;
        n_wr_rej   = r_wr_rej;
        n_rd_rem   = r_rd_rem;
        n_rd_pos   = r_rd_pos;
        n_complete = r_complete;
        n_fill     = r_fill;
        n_closing  = r_closing;
        n_item     = r_item;
        n_res      = r_res;
        n_rd_len   = r_rd_len;
        n_new_span = r_new_span;
        n_new_fill = r_new_fill;
        n_hb0      = r_hb0;
        n_hk       = r_hk;
        ram_we     = 1'b0;
        ram_waddr  = r_wp;
        ram_wdata  = '0;
        ram_raddr  = r_rp;
        span_start = 1'b0;
        span_len   = r_item.frame_length;
        frame_end  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    n_item = i_item;
                    n_res  = '0;
                    if (i_item.operation == OP_READ) begin
                        if (r_complete == '0) begin
                            n_res.status = ST_EMPTY;
                            n_state      = S_DONE;
                        end else if (r_rd_rem == '0) begin
                            n_state = S_HRD0;
                        end else begin
                            n_state = S_RDATA;
                        end
                    end else if (i_item.first_of_frame) begin
                        if (r_wr_rem != '0) begin
                            n_closing = 1'b1;
                            n_state   = S_PUT;
                        end else begin
                            span_start = 1'b1;
                            span_len   = i_item.frame_length;
                            n_state    = S_NSPAN;
                        end
                    end else if (r_wr_rem != '0 && !r_wr_rej) begin
                        n_state = S_PUT;
                    end else begin
                        n_res.status = ST_REJECT;
                        n_state      = S_DONE;
                    end
                end
            end

            // One data byte; a closing frame writes zeros until its count runs out.
            S_PUT: begin
                ram_we    = 1'b1;
                ram_wdata = r_closing ? '0 : r_item.data_byte;
                n_wp      = r_wp + AW'(1);
                n_wr_rem  = r_wr_rem - LEN_W'(1);
                if (r_wr_rem == LEN_W'(1)) begin
                    if (r_fill != '0) begin
                        n_state = S_PAD;
                    end else begin
                        frame_end = 1'b1;
                    end
                end else if (!r_closing) begin
                    n_state = S_DONE;
                end
            end

            S_PAD: begin
                ram_we = 1'b1;
                n_wp   = r_wp + AW'(1);
                n_fill = r_fill - FILL_W'(1);
                if (r_fill == FILL_W'(1)) begin
                    frame_end = 1'b1;
                end
            end

            // Span of the new frame is ready; screen out lengths that can never fit.
            S_NSPAN: begin
                if (span_done) begin
                    n_new_span = span_out;
                    n_new_fill = fill_out;
                    if (len_bad) begin
                        n_wr_rej     = 1'b1;
                        n_res.status = ST_REJECT;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end

            // Fit test; recycle the oldest frame while allowed and needed.
            S_CHECK: begin
                if (32'(r_new_span) > 32'(r_free)) begin
                    if (!i_drop_oldest || r_complete == '0) begin
                        n_wr_rej     = 1'b1;
                        n_res.status = ST_REJECT;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_HRD0;
                    end
                end else begin
                    n_hk    = '0;
                    n_state = S_HWR;
                end
            end

            S_HRD0: begin
                ram_raddr = r_rp;
                n_state   = S_HRD1;
            end

            S_HRD1: begin
                n_hb0     = ram_rdata;
                ram_raddr = r_rp + AW'(1);
                n_state   = S_HRD2;
            end

            // Header length is known: start a read or size the frame to recycle.
            S_HRD2: begin
                if (r_item.operation == OP_READ) begin
                    n_rd_len = hlen;
                    n_rd_rem = hlen;
                    n_rd_pos = '0;
                    n_state  = S_RDATA;
                end else begin
                    span_start = 1'b1;
                    span_len   = hlen;
                    n_state    = S_RSPAN;
                end
            end

            S_RSPAN: begin
                if (span_done) begin
                    n_rp                 = r_rp + AW'(span_out);
                    n_free               = r_free + FREE_W'(span_out);
                    n_complete           = r_complete - AW'(1);
                    n_rd_rem             = '0;
                    n_rd_pos             = '0;
                    n_res.frames_dropped = r_res.frames_dropped + DROP_W'(1);
                    n_state              = S_CHECK;
                end
            end

            // Header bytes, low byte first; then the frame opens with its first byte.
            S_HWR: begin
                ram_we    = 1'b1;
                ram_wdata = hdr_word[BYTE_W-1:0];
                n_wp      = r_wp + AW'(1);
                n_hk      = r_hk + HK_W'(1);
                if (r_hk == HK_W'(HEAD_BYTES - 1)) begin
                    n_free   = r_free - FREE_W'(r_new_span);
                    n_wr_rem = r_item.frame_length;
                    n_fill   = r_new_fill;
                    n_wr_rej = 1'b0;
                    n_state  = S_PUT;
                end
            end

            S_RDATA: begin
                ram_raddr = r_rp + AW'(HEAD_BYTES) + AW'(r_rd_pos);
                n_state   = S_RBYTE;
            end

            S_RBYTE: begin
                if (r_rd_pos < r_item.read_limit) begin
                    n_res.read_byte = ram_rdata;
                end else begin
                    n_res.status = ST_DISCARD;
                end
                n_rd_pos = r_rd_pos + LEN_W'(1);
                n_rd_rem = r_rd_rem - LEN_W'(1);
                if (r_rd_rem == LEN_W'(1)) begin
                    n_res.end_of_frame = 1'b1;
                    span_start         = 1'b1;
                    span_len           = r_rd_len;
                    n_state            = S_ESPAN;
                end else begin
                    n_state = S_DONE;
                end
            end

            // Release the frame that was read to the end.
            S_ESPAN: begin
                if (span_done) begin
                    n_rp       = r_rp + AW'(span_out);
                    n_free     = r_free + FREE_W'(span_out);
                    n_complete = r_complete - AW'(1);
                    n_rd_pos   = '0;
                    n_state    = S_DONE;
                end
            end

            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A frame has all its bytes: count it, then go on with the new frame if closing.
        if (frame_end) begin
            n_complete = r_complete + AW'(1);
            if (r_closing) begin
                n_closing  = 1'b0;
                span_start = 1'b1;
                span_len   = r_item.frame_length;
                n_state    = S_NSPAN;
            end else begin
                n_state = S_DONE;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_wp       <= '0;
            r_rp       <= '0;
            r_free     <= FREE_W'(BUF_BYTES);
            r_wr_rem   <= '0;
            r_wr_rej   <= 1'b0;
            r_rd_rem   <= '0;
            r_rd_pos   <= '0;
            r_complete <= '0;
            r_fill     <= '0;
            r_closing  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_wp       <= n_wp;
            r_rp       <= n_rp;
            r_free     <= n_free;
            r_wr_rem   <= n_wr_rem;
            r_wr_rej   <= n_wr_rej;
            r_rd_rem   <= n_rd_rem;
            r_rd_pos   <= n_rd_pos;
            r_complete <= n_complete;
            r_fill     <= n_fill;
            r_closing  <= n_closing;
        end
    end

    // Working data registers.
    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_res      <= n_res;
        r_rd_len   <= n_rd_len;
        r_new_span <= n_new_span;
        r_new_fill <= n_new_fill;
        r_hb0      <= n_hb0;
        r_hk       <= n_hk;
    end

endmodule

`default_nettype wire

/* hw/rtl/frame_ring_buffer_with_drop_core.sv */
// ----------------------------------------------------------------------------
// frame_ring_buffer_with_drop_core
// Length-prefixed frame ring buffer that can recycle its oldest frames.
//
// Channel     Dir   Transfer holds
// s_axis      in    one command: write a frame byte or read one byte
// m_axis      out   one result per command
// APB         in    drop_oldest register at byte address 0
//
// A write byte goes into the ring, and a frame's last byte also writes the fill.
// A read fetches one byte; a frame's first byte reads the length header first,
// and its last byte releases the frame through the span unit. A new frame first
// closes an open frame with zero bytes, is sized in the span unit, recycles old
// frames as needed and writes its header; the single ring RAM port and the
// shared span unit serialize these steps. Reset is synchronous; ring contents
// are not cleared, since no entry is read before it is written. A result waits
// in the output register without blocking the next command transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_ring_buffer_with_drop_core
    import frb_pkg::*;
#(
    parameter int BUF_BYTES   = DEF_BUF_BYTES,
    parameter int HEAD_BYTES  = DEF_HEAD_BYTES,
    parameter int ALIGN_BYTES = DEF_ALIGN_BYTES
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Configuration port.
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [APB_AW-1:0]    paddr,
    input  wire logic [APB_DW-1:0]    pwdata,
    output logic      [APB_DW-1:0]    prdata,
    output logic                      pready,
    // Command stream.
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // [9:0] frame_length, [17:10] data_byte, [27:18] read_limit, [31:28] zero
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // [0] operation, [1] first_of_frame
    input  wire logic [S_TUSER_W-1:0] s_axis_tuser,
    // Result stream.
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // [7:0] read_byte, [16:8] frames_dropped, [23:17] zero
    output logic      [M_TDATA_W-1:0] m_axis_tdata,
    // [1:0] status
    output logic      [M_TUSER_W-1:0] m_axis_tuser,
    output logic                      m_axis_tlast
);

    logic                 r_drop_oldest;
    logic                 cfg_we;
    t_item                item;
    t_result              res;
    logic                 res_valid;
    logic                 out_free;
    logic                 r_m_valid;
    logic [M_TDATA_W-1:0] r_m_data;
    logic [M_TUSER_W-1:0] r_m_user;
    logic                 r_m_last;

    // Configuration register.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_DROP_OLDEST) ? APB_DW'(r_drop_oldest) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop_oldest <= 1'b1;
        end else if (cfg_we && paddr[2] == REG_DROP_OLDEST) begin
            r_drop_oldest <= pwdata[0];
        end
    end

    // Unpack the command.
    always_comb begin
        item.operation      = s_axis_tuser[0];
        item.first_of_frame = s_axis_tuser[1];
        item.frame_length   = s_axis_tdata[9:0];
        item.data_byte      = s_axis_tdata[17:10];
        item.read_limit     = s_axis_tdata[27:18];
    end

    frb_seq #(
        .BUF_BYTES   (BUF_BYTES),
        .HEAD_BYTES  (HEAD_BYTES),
        .ALIGN_BYTES (ALIGN_BYTES)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (s_axis_tvalid),
        .o_item_ready  (s_axis_tready),
        .i_item        (item),
        .i_drop_oldest (r_drop_oldest),
        .i_out_free    (out_free),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    // Output register.
    assign out_free = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_valid) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_m_data <= M_TDATA_W'({res.frames_dropped, res.read_byte});
            r_m_user <= res.status;
            r_m_last <= res.end_of_frame;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;
    assign m_axis_tlast  = r_m_last;

endmodule

`default_nettype wire

/* hw/rtl/frb_checker.sv */
// ----------------------------------------------------------------------------
// frb_checker
// Port-level checks of the frame ring buffer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module frb_checker
    import frb_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 s_axis_tvalid,
    input wire logic                 s_axis_tready,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [M_TDATA_W-1:0] m_axis_tdata,
    input wire logic [M_TUSER_W-1:0] m_axis_tuser,
    input wire logic                 m_axis_tlast
);

    // A command transfer starts work, so the next cycle is busy.
    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("command accepted while previous one still in work");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
        $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // Only a good read delivers a data byte.
    a_byte_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata[7:0] == 8'd0)
        else $error("data byte on a result that is not ok");

    // End of frame comes from a read, which never recycles frames.
    a_eof_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |->
        (m_axis_tuser == ST_OK || m_axis_tuser == ST_DISCARD) &&
        m_axis_tdata[16:8] == 9'd0)
        else $error("end of frame on a result that is not a read");

endmodule

bind frame_ring_buffer_with_drop_core frb_checker u_frb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

/* tb/frame_ring_buffer_with_drop_core_tb.sv */
// ----------------------------------------------------------------------------
// frame_ring_buffer_with_drop_core_tb
// Self-checking testbench for the length-prefixed frame ring buffer.
//
// Commands go in on the slave stream and results come back on the master
// stream, one result per command. A behavioral copy of the ring, with its own
// pointers, counters and drop policy, predicts each result when its command
// transfer happens. A checker compares every result against the oldest
// prediction. The drop policy register is written over APB only while the
// block is idle. A directed pass covers the corner cases. A pass that fills
// the ring exactly covers recycling of the largest number of frames. Random
// passes run in both drop modes with random gaps on both streams, and one
// pass runs without gaps.
// ----------------------------------------------------------------------------

module frame_ring_buffer_with_drop_core_tb
    import frb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 4;
    localparam int RING_BYTES    = DEF_BUF_BYTES;
    localparam int HDR_BYTES     = DEF_HEAD_BYTES;
    localparam int ALIGN         = DEF_ALIGN_BYTES;
    localparam int MAX_LEN       = (1 << LEN_W) - 1;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 20000;
    localparam int MAX_REPORTS   = 10;

    // Clock, reset and block ports.
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [APB_AW-1:0]    paddr = '0;
    logic [APB_DW-1:0]    pwdata = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // [9:0] frame_length, [17:10] data_byte, [27:18] read_limit, [31:28] zero
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    // [0] operation, [1] first_of_frame
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [7:0] read_byte, [16:8] frames_dropped, [23:17] zero
    logic [M_TDATA_W-1:0] m_axis_tdata;
    // [1:0] status
    logic [M_TUSER_W-1:0] m_axis_tuser;
    logic                 m_axis_tlast;

    // Shared run state.
    t_result expected_results[$];
    bit      idle_enabled = 1'b1;
    int      fail_count = 0;
    int      counted_items = 0;
    int      quiet_cycles = 0;

    // Behavioral copy of the ring and its bookkeeping.
    logic [7:0] ring_mem [RING_BYTES];
    int         wr_ptr = 0;
    int         rd_ptr = 0;
    int         free_cnt = RING_BYTES;
    int         wr_left = 0;
    bit         wr_refusing = 1'b0;
    int         rd_left = 0;
    int         rd_pos = 0;
    int         frames_held = 0;
    int         wr_pad = 0;
    bit         drop_old_cfg = 1'b1;

    frame_ring_buffer_with_drop_core #(
        .BUF_BYTES   (RING_BYTES),
        .HEAD_BYTES  (HDR_BYTES),
        .ALIGN_BYTES (ALIGN)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Zero fill that brings header, data and fill to a multiple of the alignment.
    function automatic int pad_of(int len);
        int rem;
        rem = (HDR_BYTES + len) % ALIGN;
        return (rem != 0) ? ALIGN - rem : 0;
    endfunction

    function automatic int span_of_len(int len);
        return HDR_BYTES + len + pad_of(len);
    endfunction

    // Little-endian length header of the frame stored at ring offset p.
    function automatic int stored_length(int p);
        int value;
        value = 0;
        for (int k = 0; k < HDR_BYTES; k++) begin
            value |= int'(ring_mem[(p + k) % RING_BYTES]) << (8 * k);
        end
        return value;
    endfunction

    // Store one data byte; the last one also writes the fill and closes the frame.
    function automatic void store_data_byte(logic [7:0] value);
        ring_mem[wr_ptr] = value;
        wr_ptr = (wr_ptr + 1) % RING_BYTES;
        wr_left--;
        if (wr_left == 0) begin
            while (wr_pad > 0) begin
                ring_mem[wr_ptr] = 8'h00;
                wr_ptr = (wr_ptr + 1) % RING_BYTES;
                wr_pad--;
            end
            frames_held++;
        end
    endfunction

    // Free the oldest complete frame; the reader restarts on the next one.
    function automatic bit recycle_oldest_frame();
        int span;
        if (frames_held == 0) begin
            return 1'b0;
        end
        span = span_of_len(stored_length(rd_ptr));
        rd_ptr = (rd_ptr + span) % RING_BYTES;
        free_cnt += span;
        frames_held--;
        rd_left = 0;
        rd_pos = 0;
        return 1'b1;
    endfunction

    // Advance the ring copy by one command and return the result it causes.
    function automatic t_result predict_result(t_item it);
        t_result res;
        int      len;
        int      span;
        int      flen;
        bit      ok;
        res = '0;
        len = int'(it.frame_length);
        if (it.operation == OP_WRITE) begin
            if (it.first_of_frame) begin
                span = span_of_len(len);
                while (wr_left != 0) begin
                    store_data_byte(8'h00);
                end
                ok = (len != 0) && (span <= RING_BYTES) && (len < (1 << (8 * HDR_BYTES)));
                while (ok && span > free_cnt) begin
                    if (!drop_old_cfg || !recycle_oldest_frame()) begin
                        ok = 1'b0;
                    end else begin
                        res.frames_dropped = res.frames_dropped + 1'b1;
                    end
                end
                if (ok) begin
                    for (int k = 0; k < HDR_BYTES; k++) begin
                        ring_mem[wr_ptr] = 8'((len >> (8 * k)) & 'hFF);
                        wr_ptr = (wr_ptr + 1) % RING_BYTES;
                    end
                    free_cnt -= span;
                    wr_left = len;
                    wr_pad = pad_of(len);
                    wr_refusing = 1'b0;
                    store_data_byte(it.data_byte);
                end else begin
                    wr_refusing = 1'b1;
                    res.status = ST_REJECT;
                end
            end else if (wr_left != 0 && !wr_refusing) begin
                store_data_byte(it.data_byte);
            end else begin
                res.status = ST_REJECT;
            end
        end else begin
            if (frames_held == 0) begin
                res.status = ST_EMPTY;
            end else begin
                flen = stored_length(rd_ptr);
                if (rd_left == 0) begin
                    rd_left = flen;
                    rd_pos = 0;
                end
                if (rd_pos < int'(it.read_limit)) begin
                    res.read_byte = ring_mem[(rd_ptr + HDR_BYTES + rd_pos) % RING_BYTES];
                end else begin
                    res.status = ST_DISCARD;
                end
                rd_pos++;
                rd_left--;
                if (rd_left == 0) begin
                    res.end_of_frame = 1'b1;
                    rd_ptr = (rd_ptr + span_of_len(flen)) % RING_BYTES;
                    free_cnt += span_of_len(flen);
                    frames_held--;
                    rd_pos = 0;
                end
            end
        end
        return res;
    endfunction

    function automatic t_item write_item(bit first_flag, int len, logic [7:0] value);
        t_item it;
        it = '0;
        it.operation = OP_WRITE;
        it.first_of_frame = first_flag;
        it.frame_length = LEN_W'(len);
        it.data_byte = value;
        it.read_limit = LEN_W'($urandom_range(MAX_LEN));
        return it;
    endfunction

    function automatic t_item read_item(int limit);
        t_item it;
        it = '0;
        it.operation = OP_READ;
        it.first_of_frame = 1'($urandom_range(1));
        it.frame_length = LEN_W'($urandom_range(MAX_LEN));
        it.data_byte = 8'($urandom_range(255));
        it.read_limit = LEN_W'(limit);
        return it;
    endfunction

    // Present one command, wait for its transfer, then record the prediction.
    task automatic send_item(t_item it);
        t_result res;
        if (idle_enabled) begin
            while ($urandom_range(99) < 18) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0000, it.read_limit, it.data_byte, it.frame_length};
        s_axis_tuser <= {it.first_of_frame, it.operation};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        res = predict_result(it);
        expected_results.push_back(res);
        // Bytes of no open frame are ignored and do not count toward a pass.
        if (!(it.operation == OP_WRITE && !it.first_of_frame && res.status == ST_REJECT)) begin
            counted_items++;
        end
    endtask

    // Write a frame of len bytes, of which only the first sent_bytes go out.
    task automatic send_frame(int len, int sent_bytes);
        send_item(write_item(1'b1, len, 8'($urandom_range(255))));
        for (int n = 1; n < sent_bytes; n++) begin
            send_item(write_item(1'b0, len, 8'($urandom_range(255))));
        end
    endtask

    // Stop sending and let every outstanding result come back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write with a setup and an access phase, only while the block is idle.
    task automatic write_register(int index, logic [APB_DW-1:0] value);
        wait_drained();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_AW'(4 * index);
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (index == int'(REG_DROP_OLDEST)) begin
            drop_old_cfg = value[0];
        end
    endtask

    // Field extremes, empty reads, rejected and stray bytes, early frame close,
    // discarded bytes past the read limit.
    task automatic test_directed();
        send_item(read_item(MAX_LEN));
        send_item(write_item(1'b0, 5, 8'hFF));
        send_item(write_item(1'b1, 0, 8'h00));
        send_item(write_item(1'b0, 0, 8'hFF));
        send_item(write_item(1'b1, MAX_LEN, 8'hFF));
        send_item(write_item(1'b1, 1, 8'hFF));
        send_item(write_item(1'b1, 3, 8'h00));
        send_item(write_item(1'b0, 3, 8'hAA));
        send_item(write_item(1'b0, 3, 8'h55));
        send_item(write_item(1'b1, 4, 8'h12));
        send_item(write_item(1'b0, 4, 8'h34));
        send_item(write_item(1'b1, 2, 8'h81));
        send_item(write_item(1'b0, 2, 8'h7E));
        send_item(read_item(0));
        repeat (3) send_item(read_item(2));
        repeat (4) send_item(read_item(MAX_LEN));
        repeat (2) send_item(read_item(1));
        send_item(read_item(MAX_LEN));
    endtask

    // Fill the ring exactly with minimal frames, then recycle all of them at
    // once, including the one being read; then reject in drop-new mode.
    task automatic test_ring_extremes();
        write_register(int'(REG_DROP_OLDEST), 32'd1);
        send_frame(2, 2);
        for (int n = 1; n < RING_BYTES / 4; n++) begin
            send_frame(1, 1);
        end
        send_item(read_item(MAX_LEN));
        send_item(write_item(1'b1, RING_BYTES - HDR_BYTES, 8'hC3));
        send_item(read_item(MAX_LEN));
        write_register(int'(REG_DROP_OLDEST), 32'd0);
        send_item(write_item(1'b1, 1, 8'h11));
        send_item(write_item(1'b0, 1, 8'h22));
        repeat (2) send_item(read_item(1));
        write_register(int'(REG_DROP_OLDEST), 32'd1);
        send_frame(5, 5);
        repeat (6) send_item(read_item(MAX_LEN));
    endtask

    function automatic int pick_frame_length();
        int r;
        r = $urandom_range(99);
        if (r < 88) begin
            return $urandom_range(16, 1);
        end else if (r < 98) begin
            return $urandom_range(120, 17);
        end
        return $urandom_range(400, 121);
    endfunction

    // Mostly whole frames and read bursts with random content, some truncated
    // frames and some fully random commands.
    task automatic run_random_traffic(int n_items);
        int   start_count;
        int   len;
        int   burst;
        int   limit;
        int   r;
        t_item it;
        start_count = counted_items;
        while (counted_items - start_count < n_items) begin
            r = $urandom_range(99);
            if (r < 50) begin
                len = pick_frame_length();
                send_frame(len, ($urandom_range(99) < 6) ? $urandom_range(len, 1) : len);
            end else if (r < 92) begin
                burst = $urandom_range(24, 1);
                r = $urandom_range(99);
                limit = (r < 60) ? MAX_LEN : (r < 80) ? $urandom_range(15) :
                        $urandom_range(MAX_LEN);
                for (int n = 0; n < burst; n++) begin
                    send_item(read_item(($urandom_range(9) == 0) ?
                                        $urandom_range(MAX_LEN) : limit));
                end
            end else begin
                it = '0;
                it.operation = 1'($urandom_range(1));
                it.first_of_frame = 1'($urandom_range(1));
                it.frame_length = LEN_W'(($urandom_range(1) == 0) ? $urandom_range(MAX_LEN) :
                                         $urandom_range(20));
                it.data_byte = 8'($urandom_range(255));
                it.read_limit = LEN_W'($urandom_range(MAX_LEN));
                send_item(it);
            end
        end
    endtask

    task automatic test_random_recycle();
        write_register(int'(REG_DROP_OLDEST), 32'd1);
        run_random_traffic(450);
    endtask

    task automatic test_random_reject();
        write_register(int'(REG_DROP_OLDEST), 32'd0);
        run_random_traffic(400);
    endtask

    task automatic test_back_to_back();
        write_register(int'(REG_DROP_OLDEST), 32'd1);
        idle_enabled = 1'b0;
        run_random_traffic(200);
        wait_drained();
        idle_enabled = 1'b1;
    endtask

    // Result checker and receiver-side backpressure.
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.read_byte = m_axis_tdata[7:0];
            got.frames_dropped = m_axis_tdata[16:8];
            got.status = m_axis_tuser;
            got.end_of_frame = m_axis_tlast;
            if (expected_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("unexpected result: byte %0d status %0d eof %0b dropped %0d",
                             got.read_byte, got.status, got.end_of_frame, got.frames_dropped);
                end
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("mismatch: expected byte %0d status %0d eof %0b dropped %0d, %s",
                                 want.read_byte, want.status, want.end_of_frame,
                                 want.frames_dropped, "got:");
                        $display("          actual   byte %0d status %0d eof %0b dropped %0d",
                                 got.read_byte, got.status, got.end_of_frame,
                                 got.frames_dropped);
                    end
                end
            end
        end
        m_axis_tready <= !(idle_enabled && $urandom_range(99) < 18);
    end

    // Watchdog on cycles without any transfer on either stream.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int k = 0; k < RING_BYTES; k++) begin
            ring_mem[k] = 8'h00;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_ring_extremes();
        test_random_recycle();
        test_random_reject();
        test_back_to_back();
        wait_drained();
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
